FILE: hw/rtl/fpva_pkg.sv
// shared types and codes for the fixed-point vector alu
`default_nettype none
package fpva_pkg;

	localparam int COMP_WIDTH = 32;
	localparam int FRAC_BITS  = 16;

	// operation codes
	localparam logic [2:0] FUNC_ADD   = 3'd0;
	localparam logic [2:0] FUNC_SUB   = 3'd1;
	localparam logic [2:0] FUNC_DOT   = 3'd2;
	localparam logic [2:0] FUNC_CROSS = 3'd3;
	localparam logic [2:0] FUNC_SCALE = 3'd4;
	localparam logic [2:0] FUNC_LEN   = 3'd5;
	localparam logic [2:0] FUNC_NORM  = 3'd6;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_SAT      = 2'd1;
	localparam logic [1:0] ST_ZERO_LEN = 2'd2;

	typedef struct packed {
		logic [2:0]         func;
		logic [2:0]         dims;
		logic signed [31:0] a_x;
		logic signed [31:0] a_y;
		logic signed [31:0] a_z;
		logic signed [31:0] a_w;
		logic signed [31:0] b_x;
		logic signed [31:0] b_y;
		logic signed [31:0] b_z;
		logic signed [31:0] b_w;
		logic signed [31:0] scale_factor;
	} in_t;

	typedef struct packed {
		logic signed [31:0] r_x;
		logic signed [31:0] r_y;
		logic signed [31:0] r_z;
		logic signed [31:0] r_w;
		logic signed [31:0] scalar_out;
		logic [1:0]         status;
	} out_t;

endpackage
`default_nettype wire

FILE: hw/rtl/fpva_sqrt_cell.sv
// one root bit of the pipelined integer square root
`default_nettype none
module fpva_sqrt_cell #(
	parameter int SW = 65,
	parameter int RW = 33,
	parameter int K  = 0
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [SW-1:0] rem,
	input  wire logic [RW-1:0] root,
	output logic      [SW-1:0] rem_q,
	output logic      [RW-1:0] root_q
);

	localparam int TW = SW + 1;

	logic [TW-1:0] trial;
	logic          take;

	// trial = 2*root*2^K + 2^(2K), root holds only bits above K
	always_comb begin
		trial = (TW'(root) << (K + 1)) | (TW'(1) << (2 * K));
		take  = TW'(rem) >= trial;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= take ? SW'(TW'(rem) - trial) : rem;
			root_q <= take ? (root | (RW'(1) << K)) : root;
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/fpva_div_cell.sv
// one quotient bit of the pipelined restoring divider
`default_nettype none
module fpva_div_cell #(
	parameter int NW = 48,
	parameter int DW = 33,
	parameter int K  = 0
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	input  wire logic [DW-1:0] rem,
	input  wire logic [NW-1:0] quo,
	output logic      [NW-1:0] num_q,
	output logic      [DW-1:0] rem_q,
	output logic      [NW-1:0] quo_q
);

	logic [DW:0] trial;
	logic        take;

	// bring down the next numerator bit
	always_comb begin
		trial = {rem, num[K]};
		take  = trial >= {1'b0, den};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_q <= num;
			rem_q <= take ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
			quo_q <= take ? (quo | (NW'(1) << K)) : quo;
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/fixed_point_vector_alu.sv
// top level of the fixed-point vector alu
// Fixed-point vector ALU. Each input word carries an operation (add, sub, dot,
// 3-D cross, scale, length, normalize), a dimension clamped to 2..4, two Q-format
// vectors and a scale factor; each accepted word gives exactly one result word
// with a vector, a scalar and a status (ok, saturated, zero-length normalize).
// The block is fully pipelined: a new word can enter on every clock unless the
// output stalls, and results leave in order. The depth of the pipe is set by
// the chain of CW+1 square-root cells followed by the chain of CW+FRAC_BITS
// divider cells, four divider lanes wide, at Q16.16 by default. The whole pipe
// advances together whenever the output register is empty or being taken, so
// in_ready drops only while a finished result is held back by out_ready.
`default_nettype none
module fixed_point_vector_alu #(
	parameter int COMP_WIDTH = fpva_pkg::COMP_WIDTH,
	parameter int FRAC_BITS  = fpva_pkg::FRAC_BITS
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire fpva_pkg::in_t   in_data,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output fpva_pkg::out_t       out_data
);

	// component width is capped by the 32-bit fields
	localparam int CW   = (COMP_WIDTH < 32) ? COMP_WIDTH : 32;
	localparam int F    = FRAC_BITS;
	localparam int PW   = 2 * CW;       // exact product
	localparam int SUMW = PW + 2;       // sum of four products
	localparam int SW   = 2 * CW + 1;   // sum of squares
	localparam int RW   = CW + 1;       // root
	localparam int NW   = CW + F;       // normalize numerator and quotient
	localparam int NSQ  = RW;
	localparam int NDV  = NW;

	localparam logic signed [SUMW-1:0] MAXV = {{(SUMW - CW + 1){1'b0}}, {(CW - 1){1'b1}}};
	localparam logic signed [SUMW-1:0] MINV = ~MAXV;
	localparam logic [NW-1:0]          QHALF = NW'(1) << (CW - 1);

	typedef struct packed {
		logic [2:0]             func;
		logic [2:0]             n;
		logic                   flag;
		logic [3:0][CW-1:0]     a;
		logic [3:0][CW-1:0]     r;
		logic [CW-1:0]          sc;
		logic [RW-1:0]          len;
	} ctx_t;

	function automatic logic signed [SUMW-1:0] ext(input logic signed [CW-1:0] v);
		return SUMW'(v);
	endfunction

	function automatic logic signed [SUMW-1:0] extp(input logic signed [PW-1:0] v);
		return SUMW'(v);
	endfunction

	function automatic logic ovf(input logic signed [SUMW-1:0] v);
		return (v > MAXV) || (v < MINV);
	endfunction

	function automatic logic [CW-1:0] clamp(input logic signed [SUMW-1:0] v);
		logic [CW-1:0] o;
		if (v > MAXV) begin
			o = MAXV[CW-1:0];
		end else if (v < MINV) begin
			o = MINV[CW-1:0];
		end else begin
			o = v[CW-1:0];
		end
		return o;
	endfunction

	// whole pipe moves together
	logic adv;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// stage 1: capture, take low CW bits, clamp the dimension
	logic                 v_s1;
	logic [2:0]           func_s1, n_s1;
	logic signed [CW-1:0] a_s1 [4];
	logic signed [CW-1:0] b_s1 [4];
	logic signed [CW-1:0] s_s1;
	logic [2:0]           dims_in;

	assign dims_in = in_data.dims;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			func_s1 <= in_data.func;
			n_s1    <= (dims_in < 3'd2) ? 3'd2 : ((dims_in > 3'd4) ? 3'd4 : dims_in);
			a_s1[0] <= in_data.a_x[CW-1:0];
			a_s1[1] <= in_data.a_y[CW-1:0];
			a_s1[2] <= in_data.a_z[CW-1:0];
			a_s1[3] <= in_data.a_w[CW-1:0];
			b_s1[0] <= in_data.b_x[CW-1:0];
			b_s1[1] <= in_data.b_y[CW-1:0];
			b_s1[2] <= in_data.b_z[CW-1:0];
			b_s1[3] <= in_data.b_w[CW-1:0];
			s_s1    <= in_data.scale_factor[CW-1:0];
		end
	end

	// stage 2: six multipliers, operands picked by the operation
	logic signed [CW-1:0] mx [6];
	logic signed [CW-1:0] my [6];

	always_comb begin
		for (int j = 0; j < 6; j++) begin
			mx[j] = '0;
			my[j] = '0;
		end
		unique case (func_s1)
			fpva_pkg::FUNC_DOT: begin
				for (int i = 0; i < 4; i++) begin
					if (3'(i) < n_s1) begin
						mx[i] = a_s1[i];
						my[i] = b_s1[i];
					end
				end
			end
			fpva_pkg::FUNC_CROSS: begin
				mx[0] = a_s1[1]; my[0] = b_s1[2];
				mx[1] = a_s1[2]; my[1] = b_s1[1];
				mx[2] = a_s1[2]; my[2] = b_s1[0];
				mx[3] = a_s1[0]; my[3] = b_s1[2];
				mx[4] = a_s1[0]; my[4] = b_s1[1];
				mx[5] = a_s1[1]; my[5] = b_s1[0];
			end
			fpva_pkg::FUNC_SCALE: begin
				for (int i = 0; i < 4; i++) begin
					if (3'(i) < n_s1) begin
						mx[i] = a_s1[i];
						my[i] = s_s1;
					end
				end
			end
			fpva_pkg::FUNC_LEN, fpva_pkg::FUNC_NORM: begin
				for (int i = 0; i < 4; i++) begin
					if (3'(i) < n_s1) begin
						mx[i] = a_s1[i];
						my[i] = a_s1[i];
					end
				end
			end
			default: begin
			end
		endcase
	end

	logic                 v_s2;
	logic [2:0]           func_s2, n_s2;
	logic signed [CW-1:0] a_s2 [4];
	logic signed [CW-1:0] b_s2 [4];
	logic signed [PW-1:0] p_s2 [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			func_s2 <= func_s1;
			n_s2    <= n_s1;
			a_s2    <= a_s1;
			b_s2    <= b_s1;
			for (int j = 0; j < 6; j++) begin
				p_s2[j] <= mx[j] * my[j];
			end
		end
	end

	// stage 3: sums, floor shift, saturation; sum of squares into the root chain
	logic signed [SUMW-1:0] sum_all;
	logic signed [SUMW-1:0] wr [4];
	logic signed [SUMW-1:0] wsc;
	ctx_t                   c3;

	always_comb begin
		sum_all = extp(p_s2[0]) + extp(p_s2[1]) + extp(p_s2[2]) + extp(p_s2[3]);
		for (int i = 0; i < 4; i++) begin
			wr[i] = '0;
		end
		wsc = '0;
		unique case (func_s2)
			fpva_pkg::FUNC_ADD, fpva_pkg::FUNC_SUB: begin
				for (int i = 0; i < 4; i++) begin
					if (3'(i) < n_s2) begin
						wr[i] = (func_s2 == fpva_pkg::FUNC_ADD) ?
							ext(a_s2[i]) + ext(b_s2[i]) : ext(a_s2[i]) - ext(b_s2[i]);
					end
				end
			end
			fpva_pkg::FUNC_DOT: wsc = sum_all >>> F;
			fpva_pkg::FUNC_CROSS: begin
				wr[0] = (extp(p_s2[0]) - extp(p_s2[1])) >>> F;
				wr[1] = (extp(p_s2[2]) - extp(p_s2[3])) >>> F;
				wr[2] = (extp(p_s2[4]) - extp(p_s2[5])) >>> F;
			end
			fpva_pkg::FUNC_SCALE: begin
				for (int i = 0; i < 4; i++) begin
					wr[i] = extp(p_s2[i]) >>> F;
				end
			end
			default: begin
			end
		endcase

		c3      = '0;
		c3.func = func_s2;
		c3.n    = n_s2;
		for (int i = 0; i < 4; i++) begin
			c3.a[i] = a_s2[i];
			c3.r[i] = clamp(wr[i]);
		end
		c3.sc   = clamp(wsc);
		c3.flag = ovf(wr[0]) || ovf(wr[1]) || ovf(wr[2]) || ovf(wr[3]) || ovf(wsc);
	end

	// square-root chain, one root bit per cell
	logic          v_sq    [NSQ+1];
	ctx_t          ctx_sq  [NSQ+1];
	logic [SW-1:0] rem_sq  [NSQ+1];
	logic [RW-1:0] root_sq [NSQ+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sq[0] <= 1'b0;
		end else if (adv) begin
			v_sq[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_sq[0]  <= c3;
			rem_sq[0]  <= sum_all[SW-1:0];
			root_sq[0] <= '0;
		end
	end

	for (genvar j = 0; j < NSQ; j++) begin : g_sq
		fpva_sqrt_cell #(
			.SW(SW),
			.RW(RW),
			.K (NSQ - 1 - j)
		) u_cell (
			.clk   (clk),
			.en    (adv),
			.rem   (rem_sq[j]),
			.root  (root_sq[j]),
			.rem_q (rem_sq[j+1]),
			.root_q(root_sq[j+1])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sq[j+1] <= 1'b0;
			end else if (adv) begin
				v_sq[j+1] <= v_sq[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				ctx_sq[j+1] <= ctx_sq[j];
			end
		end
	end

	// length known: finish the length op, start the divider lanes
	logic          v_dv   [NDV+1];
	ctx_t          ctx_dv [NDV+1];
	logic [NW-1:0] num_dv [NDV+1][4];
	logic [RW-1:0] rem_dv [NDV+1][4];
	logic [NW-1:0] quo_dv [NDV+1][4];
	logic          len_big;

	always_comb begin
		len_big   = root_sq[NSQ][RW-1:CW-1] != '0;
		ctx_dv[0] = ctx_sq[NSQ];
		ctx_dv[0].len = root_sq[NSQ];
		if (ctx_sq[NSQ].func == fpva_pkg::FUNC_LEN) begin
			ctx_dv[0].sc   = len_big ? MAXV[CW-1:0] : root_sq[NSQ][CW-1:0];
			ctx_dv[0].flag = ctx_sq[NSQ].flag || len_big;
		end
		v_dv[0] = v_sq[NSQ];
		for (int i = 0; i < 4; i++) begin
			// magnitude of the most negative value still fits unsigned
			num_dv[0][i] = {(ctx_sq[NSQ].a[i][CW-1] ? -ctx_sq[NSQ].a[i] : ctx_sq[NSQ].a[i]),
				{F{1'b0}}};
			rem_dv[0][i] = '0;
			quo_dv[0][i] = '0;
		end
	end

	for (genvar j = 0; j < NDV; j++) begin : g_dv
		for (genvar i = 0; i < 4; i++) begin : g_lane
			fpva_div_cell #(
				.NW(NW),
				.DW(RW),
				.K (NDV - 1 - j)
			) u_cell (
				.clk  (clk),
				.en   (adv),
				.num  (num_dv[j][i]),
				.den  (ctx_dv[j].len),
				.rem  (rem_dv[j][i]),
				.quo  (quo_dv[j][i]),
				.num_q(num_dv[j+1][i]),
				.rem_q(rem_dv[j+1][i]),
				.quo_q(quo_dv[j+1][i])
			);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_dv[j+1] <= 1'b0;
			end else if (adv) begin
				v_dv[j+1] <= v_dv[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				ctx_dv[j+1] <= ctx_dv[j];
			end
		end
	end

	// final: sign and saturate the quotients, pick status
	ctx_t          cf;
	logic [CW-1:0] rf [4];
	logic          nflag;
	logic [1:0]    stf;
	logic          qneg, qov;

	always_comb begin
		cf    = ctx_dv[NDV];
		nflag = 1'b0;
		qneg  = 1'b0;
		qov   = 1'b0;
		for (int i = 0; i < 4; i++) begin
			rf[i] = cf.r[i];
		end
		stf = fpva_pkg::ST_OK;
		if (cf.func == fpva_pkg::FUNC_NORM) begin
			if (cf.len == '0) begin
				stf = fpva_pkg::ST_ZERO_LEN;
			end else begin
				for (int i = 0; i < 4; i++) begin
					rf[i] = '0;
					if (3'(i) < cf.n) begin
						qneg = cf.a[i][CW-1];
						if (qneg) begin
							qov   = quo_dv[NDV][i] > QHALF;
							rf[i] = qov ? MINV[CW-1:0] : CW'(-quo_dv[NDV][i]);
						end else begin
							qov   = quo_dv[NDV][i] >= QHALF;
							rf[i] = qov ? MAXV[CW-1:0] : quo_dv[NDV][i][CW-1:0];
						end
						nflag = nflag || qov;
					end
				end
				if (nflag || cf.flag) begin
					stf = fpva_pkg::ST_SAT;
				end
			end
		end else if (cf.flag) begin
			stf = fpva_pkg::ST_SAT;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= v_dv[NDV];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data.r_x        <= 32'(signed'(rf[0]));
			out_data.r_y        <= 32'(signed'(rf[1]));
			out_data.r_z        <= 32'(signed'(rf[2]));
			out_data.r_w        <= 32'(signed'(rf[3]));
			out_data.scalar_out <= 32'(signed'(cf.sc));
			out_data.status     <= stf;
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/fpva_checker.sv
// port-level checks for the fixed-point vector alu, bound to the top level
`default_nettype none
module fpva_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           in_valid,
	input wire logic           in_ready,
	input wire fpva_pkg::in_t  in_data,
	input wire logic           out_valid,
	input wire logic           out_ready,
	input wire fpva_pkg::out_t out_data
);

	// status is never the unused code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.status == fpva_pkg::ST_OK ||
			out_data.status == fpva_pkg::ST_SAT ||
			out_data.status == fpva_pkg::ST_ZERO_LEN))
		else $error("bad status code");

	// zero-length normalize gives an all-zero word
	a_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status == fpva_pkg::ST_ZERO_LEN) |->
			(out_data.r_x == 0 && out_data.r_y == 0 && out_data.r_z == 0 &&
			out_data.r_w == 0 && out_data.scalar_out == 0))
		else $error("nonzero result on zero-length normalize");

	// input only held off by a stalled result
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled without output back-pressure");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("result changed while stalled");

endmodule

bind fixed_point_vector_alu fpva_checker u_fpva_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.in_data  (in_data),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data (out_data)
);
`default_nettype wire

FILE: bench/fixed_point_vector_alu_tb.sv
// self-checking testbench for the fixed-point vector alu
`timescale 1ns / 100ps
`default_nettype none
module fixed_point_vector_alu_tb;

	localparam int LATENCY  = 2 * fpva_pkg::COMP_WIDTH + fpva_pkg::FRAC_BITS + 5;
	localparam int N_RANDOM = 1030;
	localparam int WATCHDOG = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	fpva_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	fpva_pkg::out_t out_data;

	// expected result words, oldest first
	fpva_pkg::out_t result_fifo[$];
	int errors = 0;
	int words_in = 0;
	int words_out = 0;
	int idle_cycles = 0;
	int op_count[8];
	bit stim_done = 1'b0;

	fixed_point_vector_alu DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// saturate to 32-bit signed, raise flag on clip
	function automatic logic signed [31:0] clip32(input logic signed [127:0] v, inout bit f);
		if (v > 128'sd2147483647) begin
			f = 1'b1;
			return 32'sh7fffffff;
		end
		if (v < -128'sd2147483648) begin
			f = 1'b1;
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	// floor(sqrt(v)) by bisection on a wide integer
	function automatic logic [127:0] floor_sqrt(input logic [127:0] v);
		logic [127:0] lo, hi, mid;
		lo = 0;
		hi = 128'd1 << 33;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			if (mid * mid <= v) lo = mid;
			else hi = mid - 1;
		end
		return lo;
	endfunction

	function automatic fpva_pkg::out_t alu_predict(input fpva_pkg::in_t w);
		logic signed [127:0] a[4], b[4], acc, q;
		logic [127:0] len;
		logic signed [127:0] sum;
		fpva_pkg::out_t r;
		bit f;
		int n;
		r = '0;
		f = 1'b0;
		a[0] = w.a_x; a[1] = w.a_y; a[2] = w.a_z; a[3] = w.a_w;
		b[0] = w.b_x; b[1] = w.b_y; b[2] = w.b_z; b[3] = w.b_w;
		n = (w.dims < 2) ? 2 : ((w.dims > 4) ? 4 : int'(w.dims));
		sum = 0;
		for (int i = 0; i < n; i++) sum += a[i] * a[i];
		len = floor_sqrt(sum);
		// arithmetic shift floors toward minus infinity
		case (w.func)
			fpva_pkg::FUNC_ADD, fpva_pkg::FUNC_SUB, fpva_pkg::FUNC_SCALE,
			fpva_pkg::FUNC_NORM: begin
				if (w.func == fpva_pkg::FUNC_NORM && len == 0) begin
					r.status = fpva_pkg::ST_ZERO_LEN;
				end else begin
					for (int i = 0; i < n; i++) begin
						if (w.func == fpva_pkg::FUNC_ADD) acc = a[i] + b[i];
						else if (w.func == fpva_pkg::FUNC_SUB) acc = a[i] - b[i];
						else if (w.func == fpva_pkg::FUNC_SCALE)
							acc = (a[i] * 128'(signed'(w.scale_factor))) >>>
								fpva_pkg::FRAC_BITS;
						else begin
							q = (a[i] < 0 ? -a[i] : a[i]) * (128'sd1 <<< fpva_pkg::FRAC_BITS);
							q = q / signed'(len);
							acc = (a[i] < 0) ? -q : q;
						end
						case (i)
							0: r.r_x = clip32(acc, f);
							1: r.r_y = clip32(acc, f);
							2: r.r_z = clip32(acc, f);
							default: r.r_w = clip32(acc, f);
						endcase
					end
				end
			end
			fpva_pkg::FUNC_DOT: begin
				acc = 0;
				for (int i = 0; i < n; i++) acc += a[i] * b[i];
				r.scalar_out = clip32(acc >>> fpva_pkg::FRAC_BITS, f);
			end
			fpva_pkg::FUNC_CROSS: begin
				r.r_x = clip32((a[1] * b[2] - a[2] * b[1]) >>> fpva_pkg::FRAC_BITS, f);
				r.r_y = clip32((a[2] * b[0] - a[0] * b[2]) >>> fpva_pkg::FRAC_BITS, f);
				r.r_z = clip32((a[0] * b[1] - a[1] * b[0]) >>> fpva_pkg::FRAC_BITS, f);
			end
			fpva_pkg::FUNC_LEN: r.scalar_out = clip32(signed'(len), f);
			default: ;
		endcase
		if (r.status == fpva_pkg::ST_OK && f) r.status = fpva_pkg::ST_SAT;
		return r;
	endfunction

	// directed row: stimulus word plus an optional typed-in answer
	typedef struct {
		fpva_pkg::in_t  w;
		bit             fixed;
		fpva_pkg::out_t ans;
	} row_t;

	row_t rows[$];

	function automatic fpva_pkg::in_t mk(input logic [2:0] f, input logic [2:0] d,
			input logic [31:0] av, input logic [31:0] bv, input logic [31:0] s);
		fpva_pkg::in_t w;
		w.func = f; w.dims = d;
		w.a_x = av; w.a_y = av; w.a_z = av; w.a_w = av;
		w.b_x = bv; w.b_y = bv; w.b_z = bv; w.b_w = bv;
		w.scale_factor = s;
		return w;
	endfunction

	function automatic fpva_pkg::out_t res(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z, input logic [31:0] ww, input logic [31:0] s,
			input logic [1:0] st);
		fpva_pkg::out_t r;
		r.r_x = x; r.r_y = y; r.r_z = z; r.r_w = ww; r.scalar_out = s; r.status = st;
		return r;
	endfunction

	task automatic add_row(input fpva_pkg::in_t w, input bit fx, input fpva_pkg::out_t a);
		row_t r;
		r.w = w; r.fixed = fx; r.ans = a;
		rows.push_back(r);
	endtask

	function automatic logic [31:0] rnd_comp();
		case ($urandom_range(0, 7))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(0, 8) << 16;
			3: return -($urandom_range(0, 8) << 16);
			4: return $urandom_range(0, 1) ? 32'h0 : 32'hffffffff;
			5: return $signed($urandom_range(0, 32'h0003ffff)) - 32'sh00020000;
			default: return $urandom;
		endcase
	endfunction

	function automatic fpva_pkg::in_t rnd_word();
		fpva_pkg::in_t w;
		w.func = ($urandom_range(0, 19) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
		w.dims = ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'($urandom_range(2, 4));
		w.a_x = rnd_comp(); w.a_y = rnd_comp(); w.a_z = rnd_comp(); w.a_w = rnd_comp();
		w.b_x = rnd_comp(); w.b_y = rnd_comp(); w.b_z = rnd_comp(); w.b_w = rnd_comp();
		w.scale_factor = rnd_comp();
		if (w.func == fpva_pkg::FUNC_NORM && $urandom_range(0, 5) == 0) begin
			w.a_x = 0; w.a_y = 0; w.a_z = 0; w.a_w = 0;
		end
		return w;
	endfunction

	// hand one word to the block, hold it until accepted
	task automatic push_word(input fpva_pkg::in_t w, input bit fx, input fpva_pkg::out_t a);
		in_data <= w;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		result_fifo.push_back(fx ? a : alu_predict(w));
		words_in++;
		op_count[w.func]++;
		@(negedge clk);
	endtask

	// stimulus
	initial begin
		int burst;
		int gap;
		bit drained;
		drained = 1'b0;
		for (int i = 0; i < 8; i++) op_count[i] = 0;
		add_row(mk(fpva_pkg::FUNC_ADD, 3'd4, 32'h0, 32'h0, 32'h0), 1,
			res(0, 0, 0, 0, 0, fpva_pkg::ST_OK));
		add_row(mk(fpva_pkg::FUNC_ADD, 3'd4, 32'h7fffffff, 32'h7fffffff, 0), 1,
			res(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0,
				fpva_pkg::ST_SAT));
		add_row(mk(fpva_pkg::FUNC_SUB, 3'd4, 32'h80000000, 32'h7fffffff, 0), 1,
			res(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 0,
				fpva_pkg::ST_SAT));
		add_row(mk(fpva_pkg::FUNC_ADD, 3'd2, 32'h00010000, 32'h00010000, 0), 1,
			res(32'h00020000, 32'h00020000, 0, 0, 0, fpva_pkg::ST_OK));
		add_row(mk(fpva_pkg::FUNC_DOT, 3'd3, 32'h00010000, 32'h00020000, 0), 1,
			res(0, 0, 0, 0, 32'h00060000, fpva_pkg::ST_OK));
		add_row(mk(fpva_pkg::FUNC_DOT, 3'd4, 32'h80000000, 32'h80000000, 0), 1,
			res(0, 0, 0, 0, 32'h7fffffff, fpva_pkg::ST_SAT));
		add_row(mk(fpva_pkg::FUNC_CROSS, 3'd2, 32'h00010000, 32'h00010000, 0), 1,
			res(0, 0, 0, 0, 0, fpva_pkg::ST_OK));
		add_row(mk(fpva_pkg::FUNC_SCALE, 3'd4, 32'h00030000, 0, 32'h80000000), 1,
			res(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 0,
				fpva_pkg::ST_SAT));
		add_row(mk(fpva_pkg::FUNC_LEN, 3'd4, 32'h00030000, 0, 0), 1,
			res(0, 0, 0, 0, 32'h00060000, fpva_pkg::ST_OK));
		add_row(mk(fpva_pkg::FUNC_LEN, 3'd4, 32'h80000000, 0, 0), 1,
			res(0, 0, 0, 0, 32'h7fffffff, fpva_pkg::ST_SAT));
		// zero vector in normalize
		add_row(mk(fpva_pkg::FUNC_NORM, 3'd3, 32'h0, 32'h5, 32'h5), 1,
			res(0, 0, 0, 0, 0, fpva_pkg::ST_ZERO_LEN));
		// undefined operation code
		add_row(mk(3'd7, 3'd4, 32'h12345678, 32'h9abcdef0, 32'h1), 1,
			res(0, 0, 0, 0, 0, fpva_pkg::ST_OK));
		// dims out of range and other edge operands, checked against the predictor
		add_row(mk(fpva_pkg::FUNC_ADD, 3'd0, 32'h00018000, 32'hfffe0000, 0), 0, '0);
		add_row(mk(fpva_pkg::FUNC_ADD, 3'd7, 32'h00018000, 32'hfffe0000, 0), 0, '0);
		add_row(mk(fpva_pkg::FUNC_NORM, 3'd4, 32'hffff0000, 0, 0), 0, '0);
		add_row(mk(fpva_pkg::FUNC_NORM, 3'd2, 32'h00000001, 0, 0), 0, '0);
		add_row(mk(fpva_pkg::FUNC_NORM, 3'd4, 32'h80000000, 0, 0), 0, '0);
		add_row(mk(fpva_pkg::FUNC_SCALE, 3'd3, 32'hffff8001, 0, 32'h7fffffff), 0, '0);
		add_row(mk(fpva_pkg::FUNC_CROSS, 3'd4, 32'h7fffffff, 32'h80000000, 0), 0, '0);
		add_row(mk(fpva_pkg::FUNC_DOT, 3'd1, 32'hfffffffd, 32'h00000003, 0), 0, '0);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (rows[i]) push_word(rows[i].w, rows[i].fixed, rows[i].ans);

		for (int k = 0; k < N_RANDOM; ) begin
			// drain the pipe once midway
			if (!drained && k >= N_RANDOM / 2) begin
				drained = 1'b1;
				in_valid <= 1'b0;
				while (result_fifo.size() != 0) @(negedge clk);
			end
			burst = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
			for (int j = 0; j < burst && k < N_RANDOM; j++, k++)
				push_word(rnd_word(), 0, '0);
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		in_valid <= 1'b0;
		stim_done = 1'b1;
	end

	// receiver stall pattern: long open runs, short random stalls
	always @(negedge clk) begin
		if (!arst_n) out_ready <= 1'b0;
		else if ((words_out / 64) % 3 == 2) out_ready <= 1'b1;
		else out_ready <= ($urandom_range(0, 9) > 2);
	end

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			words_out++;
			if (result_fifo.size() == 0) begin
				$display("%0t: unexpected result word %h", $time, out_data);
				errors++;
			end else begin
				fpva_pkg::out_t e;
				e = result_fifo.pop_front();
				if (e !== out_data) begin
					$display("%0t: mismatch expected x=%h y=%h z=%h w=%h s=%h st=%0d",
						$time, e.r_x, e.r_y, e.r_z, e.r_w, e.scalar_out, e.status);
					$display("%0t:          actual   x=%h y=%h z=%h w=%h s=%h st=%0d",
						$time, out_data.r_x, out_data.r_y, out_data.r_z,
						out_data.r_w, out_data.scalar_out, out_data.status);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("%0t: timeout with %0d words outstanding", $time, result_fifo.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// end of run
	initial begin
		wait (stim_done);
		while (result_fifo.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		$display("covered %0d words in, %0d out, %0d errors", words_in, words_out, errors);
		$display("per op add %0d sub %0d dot %0d cross %0d scale %0d len %0d norm %0d bad %0d",
			op_count[0], op_count[1], op_count[2], op_count[3],
			op_count[4], op_count[5], op_count[6], op_count[7]);
		if (errors == 0 && result_fifo.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire
